>>> src/ftiq_pkg.sv
// ----------------------------------------------------------------------------
// ftiq_pkg
// shared constants and types for the float to int quantizer
// ----------------------------------------------------------------------------
package ftiq_pkg;

   localparam int unsigned FloatWidth = 32;
   localparam int unsigned QuantWidth = 16;
   localparam int unsigned CsrAddrWidth = 1;

   localparam logic [CsrAddrWidth-1:0] CSR_SCALE  = 1'b0;
   localparam logic [CsrAddrWidth-1:0] CSR_NARROW = 1'b1;

   localparam logic signed [QuantWidth-1:0] Q16_MAX = 16'sh7fff;
   localparam logic signed [QuantWidth-1:0] Q16_MIN = -16'sh8000;
   localparam logic signed [QuantWidth-1:0] Q8_MAX  = 16'sd127;
   localparam logic signed [QuantWidth-1:0] Q8_MIN  = -16'sd127;

   // decoded product handed from the multiplier stage to the convert stage
   typedef struct packed {
      logic        is_zero;   // product magnitude below one half
      logic        is_big;    // nan, inf or magnitude >= 2^31 before rounding
      logic        sign;
      logic [7:0]  exp;       // biased exponent of rounded product
      logic [23:0] mant;      // rounded mantissa with hidden bit
   } prod_type;

endpackage

>>> src/float_to_int_quantizer_core.sv
// ----------------------------------------------------------------------------
// float_to_int_quantizer_core
// float32 times scale, rounded to int32, saturated to int16 or int8
// start to rsp_valid passes the product register and then the result register
// throughput: one transfer per cycle, busy is always low
// reset: synchronous, scale 1.0, 16-bit mode, pipeline emptied
// receiver cannot stall: results leave as the strobe pulses
// ----------------------------------------------------------------------------
module float_to_int_quantizer_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [31:0]              req_sample_bits,
   input  logic                     req_last_in,
   output logic                     rsp_valid,
   output logic signed [15:0]       rsp_quantized,
   output logic                     rsp_last_out,
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [ftiq_pkg::CsrAddrWidth-1:0] csr_index,
   input  logic [31:0]              csr_data
);
   import ftiq_pkg::*;

   logic [31:0] scale_ff;
   logic        narrow_ff;
   prod_type    prod_in, prod_ff;
   logic        v1_ff, last1_ff;
   logic        v2_ff, last2_ff;
   logic signed [15:0] q_ff, q_in;

   // bits of the product below and above the binary point
   logic [5:0]  sh;
   logic [55:0] fix;     // integer in [55:24], fraction [23:0]
   logic [31:0] ipart;
   logic        half, frac_rest;
   logic [32:0] mag;
   logic signed [33:0] ival;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= 32'h3f80_0000;
         narrow_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_data;
            CSR_NARROW: narrow_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // stage one: multiply
   ftiq_fmul u_fmul (
      .a    (req_sample_bits),
      .b    (scale_ff),
      .prod (prod_in)
   );

   // stage two: round to integer and saturate
   always_comb begin
      // exp in 126..157 here; value = mant * 2^(exp-150)
      sh = 6'(prod_ff.exp - 8'd126);            // 0..31
      fix = {32'b0, prod_ff.mant} << sh;         // mant*2^(exp-126), frac is 24 bits
      // fraction is fix[23:0] scaled by 2^-24, integer fix[55:24]
      ipart = fix[55:24];
      half  = fix[23];
      frac_rest = fix[22:0] != '0;
      mag = {1'b0, ipart} + 33'((half && (frac_rest || ipart[0])) ? 1 : 0);
      ival = prod_ff.sign ? -34'(signed'({1'b0, mag})) : 34'(signed'({1'b0, mag}));
      if (prod_ff.is_zero) begin
         ival = '0;
      end
      if (prod_ff.is_big || ival > 34'sd2147483647) begin
         ival = -34'sd2147483648;
      end
      if (ival > 34'(Q16_MAX))      q_in = Q16_MAX;
      else if (ival < 34'(Q16_MIN)) q_in = Q16_MIN;
      else                          q_in = 16'(ival);
      if (narrow_ff) begin
         if (q_in > Q8_MAX)      q_in = Q8_MAX;
         else if (q_in < Q8_MIN) q_in = Q8_MIN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= start && !busy;
         v2_ff <= v1_ff;
      end
      prod_ff  <= prod_in;
      last1_ff <= req_last_in;
      q_ff     <= q_in;
      last2_ff <= last1_ff;
   end

   assign rsp_valid     = v2_ff;
   assign rsp_quantized = q_ff;
   assign rsp_last_out  = last2_ff;

   // every accepted request shows up on rsp_valid after passing v1_ff and v2_ff
   a_lat: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid) else $error("lost result");
   a_narrow: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && $past(narrow_ff)) |-> (rsp_quantized >= Q8_MIN && rsp_quantized <= Q8_MAX))
      else $error("narrow range");
   a_nores: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(v1_ff)) else $error("spurious result");
endmodule

>>> src/ftiq_fmul.sv
// ----------------------------------------------------------------------------
// ftiq_fmul
// single precision multiply, round to nearest even, subnormals kept
// ----------------------------------------------------------------------------
module ftiq_fmul (
   input  logic [31:0]        a,
   input  logic [31:0]        b,
   output ftiq_pkg::prod_type prod
);
   import ftiq_pkg::*;

   logic        sa, sb, sp;
   logic [7:0]  ea, eb;
   logic [22:0] fa, fb;
   logic        a_nan, b_nan, a_inf, b_inf, a_z, b_z;
   logic [23:0] ma, mb;
   logic [47:0] raw;
   logic [5:0]  lz;
   logic [47:0] norm;
   logic signed [10:0] e_norm;  // exponent of norm[47]
   logic [48:0] shifted;        // extra sticky bit at position 0
   logic [5:0]  rsh;
   logic [24:0] keep;
   logic        g, st;
   logic [24:0] rnd;
   logic signed [10:0] e_fin;
   logic [23:0] m_fin;
   logic [7:0]  e_out;

   always_comb begin
      sa = a[31]; sb = b[31]; sp = sa ^ sb;
      ea = a[30:23]; eb = b[30:23];
      fa = a[22:0];  fb = b[22:0];
      a_nan = (ea == 8'hff) && (fa != '0);
      b_nan = (eb == 8'hff) && (fb != '0);
      a_inf = (ea == 8'hff) && (fa == '0);
      b_inf = (eb == 8'hff) && (fb == '0);
      a_z   = (ea == 8'h00) && (fa == '0);
      b_z   = (eb == 8'h00) && (fb == '0);
      ma = {(ea != 8'h00), fa};
      mb = {(eb != 8'h00), fb};
      raw = ma * mb;
      lz = 6'd0;
      for (int i = 0; i < 48; i++) begin
         if (raw[i]) lz = 6'(47 - i);
      end
      norm = raw << lz;
      // value = norm * 2^(ea' + eb' - 254 - 46 - lz), norm[47] weighted 2^(e-127)
      e_norm = 11'(signed'({3'b0, (ea == 8'h00) ? 8'd1 : ea}))
             + 11'(signed'({3'b0, (eb == 8'h00) ? 8'd1 : eb}))
             - 11'sd126 - 11'(signed'({5'b0, lz}));
      // subnormal result: shift right so exponent field becomes 1
      if (e_norm < 11'sd1) begin
         rsh = ((11'sd1 - e_norm) > 11'sd30) ? 6'd30 : 6'(11'sd1 - e_norm);
      end else begin
         rsh = 6'd0;
      end
      shifted = {norm, 1'b0} >> rsh;
      st = (({norm, 1'b0} & ~({49{1'b1}} << rsh)) != '0) || (shifted[23:0] != '0);
      keep = {1'b0, shifted[48:25]};
      g  = shifted[24];
      rnd = keep + 25'((g && (st || keep[0])) ? 1 : 0);
      e_fin = (e_norm < 11'sd1) ? 11'sd1 : e_norm;
      if (rnd[24]) begin
         m_fin = rnd[24:1];
         e_fin = e_fin + 11'sd1;
      end else begin
         m_fin = rnd[23:0];
      end
      e_out = (e_fin > 11'sd254) ? 8'hff : 8'(e_fin);

      prod.sign = sp;
      prod.exp  = e_out;
      prod.mant = m_fin;
      prod.is_big = a_nan || b_nan || a_inf || b_inf || (e_fin > 11'sd157);
      prod.is_zero = !prod.is_big && (a_z || b_z || raw == '0 || m_fin == '0
                     || e_fin < 11'sd126);
   end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// streams float32 samples through the quantizer under several scale and
// width settings, predicts each int16 or int8 result bit-exactly with
// integer arithmetic and checks every result strobe in order
// ----------------------------------------------------------------------------
module testbench;
   import ftiq_pkg::*;

   localparam int unsigned ClockHalf = 6;
   localparam int unsigned ResetCycles = 5;
   localparam int unsigned DrainCycles = 6;
   localparam int unsigned ReportLimit = 10;
   localparam longint NarrowFloor = -128;
   localparam longint IntIndefinite = -64'sd2147483648;
   localparam longint Int32Span = 64'sd2147483648;

   typedef struct {
      logic [31:0] sample;
      logic        last;
   } sample_item_type;

   typedef struct {
      logic signed [QuantWidth-1:0] quantized;
      logic                         last;
   } quant_result_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         start = 1'b0;
   logic                         busy;
   logic [31:0]                  req_sample_bits = '0;
   logic                         req_last_in = 1'b0;
   logic                         rsp_valid;
   logic signed [QuantWidth-1:0] rsp_quantized;
   logic                         rsp_last_out;
   logic                         csr_valid = 1'b0;
   logic                         csr_ready;
   logic [CsrAddrWidth-1:0]      csr_index = '0;
   logic [31:0]                  csr_data = '0;

   // shadow copy of the block's registers
   logic [31:0] model_scale = 32'h3f80_0000;
   logic        model_narrow = 1'b0;

   sample_item_type  pending_samples[$];
   quant_result_type expected_quants[$];
   int               mismatch_count = 0;
   int               gap_left = 0;

   float_to_int_quantizer_core i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_sample_bits (req_sample_bits),
      .req_last_in     (req_last_in),
      .rsp_valid       (rsp_valid),
      .rsp_quantized   (rsp_quantized),
      .rsp_last_out    (rsp_last_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #(ClockHalf) clock = ~clock;

   // shift right with round to nearest, ties to even
   function automatic longint unsigned round_shift(longint unsigned v, int sh);
      longint unsigned q;
      longint unsigned rem;
      longint unsigned half;
      q = v >> sh;
      rem = v & ((64'd1 << sh) - 1);
      half = 64'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
      return q;
   endfunction

   // float32 product rounded to single, then to int32, then saturated
   function automatic logic signed [QuantWidth-1:0] quantize_sample(
      logic [31:0] smp, logic [31:0] scl, logic narrow);
      int              ea;
      int              eb;
      int              e;
      int              e2;
      int              p;
      int              sh;
      longint unsigned ma;
      longint unsigned mb;
      longint unsigned m;
      longint unsigned r;
      longint unsigned mag;
      logic            big;
      longint          v;
      big = 1'b0;
      mag = 0;
      ea = smp[30:23];
      eb = scl[30:23];
      // nan or infinity in either operand ends as the indefinite integer
      if (ea == 255 || eb == 255) begin
         big = 1'b1;
      end else begin
         ma = (ea != 0) ? {1'b1, smp[22:0]} : smp[22:0];
         mb = (eb != 0) ? {1'b1, scl[22:0]} : scl[22:0];
         if (ea == 0) ea = 1;
         if (eb == 0) eb = 1;
         m = ma * mb;
         if (m != 0) begin
            e = ea + eb - 300;
            p = 63;
            while (!m[p]) p--;
            // keep 24 significant bits, fewer when the product is subnormal
            sh = p - 23;
            if (-149 - e > sh) sh = -149 - e;
            e2 = e;
            if (sh > 60) begin
               r = 0;
            end else if (sh > 0) begin
               r = round_shift(m, sh);
               e2 = e + sh;
            end else begin
               r = m;
            end
            if (r != 0) begin
               if (e2 >= 8) begin
                  big = 1'b1;
               end else if (e2 >= 0) begin
                  mag = r << e2;
               end else if (-e2 <= 40) begin
                  mag = round_shift(r, -e2);
               end
               if (mag >= Int32Span) big = 1'b1;
            end
         end
      end
      if (big) v = IntIndefinite;
      else v = (smp[31] ^ scl[31]) ? -longint'(mag) : longint'(mag);
      if (v < longint'(Q16_MIN)) v = Q16_MIN;
      if (v > longint'(Q16_MAX)) v = Q16_MAX;
      if (narrow) begin
         if (v < NarrowFloor) v = NarrowFloor;
         if (v > longint'(Q8_MAX)) v = Q8_MAX;
         if (v < longint'(Q8_MIN)) v = Q8_MIN;
      end
      return v[QuantWidth-1:0];
   endfunction

   // mostly short gaps, some long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(6, 20);
   endfunction

   // sample aimed so the product lands near the integer range, plus noise
   function automatic logic [31:0] random_sample(logic [31:0] scl);
      int          roll;
      int          ex;
      logic [31:0] s;
      roll = $urandom_range(0, 9);
      s = $urandom();
      if (roll < 2) return s;
      if (roll == 2) begin
         case ($urandom_range(0, 4))
            0: return {s[31], 31'h0};
            1: return {s[31], 8'hff, 23'h0};
            2: return {s[31], 8'hff, s[22:0] | 23'h1};
            3: return {s[31], 8'h00, s[22:0]};
            default: return {s[31], 8'hfe, s[22:0]};
         endcase
      end
      ex = $urandom_range(118, 160) - int'(scl[30:23]) + 127;
      if (ex < 0) ex = 0;
      if (ex > 254) ex = 254;
      return {s[31], 8'(ex), s[22:0]};
   endfunction

   // sender: pops queued samples and holds each until the transfer
   always @(posedge clock) begin
      sample_item_type item;
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         if (start && !busy) begin
            expected_quants.push_back('{quantize_sample(req_sample_bits, model_scale,
                                       model_narrow), req_last_in});
         end
         if (start && busy) begin
            // item still waiting for its transfer
         end else if (gap_left > 0) begin
            start <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pending_samples.size() > 0) begin
            item = pending_samples.pop_front();
            req_sample_bits <= item.sample;
            req_last_in <= item.last;
            start <= 1'b1;
            gap_left <= pick_gap();
         end else begin
            start <= 1'b0;
         end
      end
   end

   // result side: every strobe must match the oldest prediction
   always @(posedge clock) begin
      quant_result_type want;
      if (!reset && rsp_valid) begin
         if (expected_quants.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= ReportLimit)
               $display("unexpected result quantized=%0d last=%0b",
                        rsp_quantized, rsp_last_out);
         end else begin
            want = expected_quants.pop_front();
            if (rsp_quantized !== want.quantized || rsp_last_out !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= ReportLimit)
                  $display("mismatch: quantized exp %0d got %0d, last exp %0b got %0b",
                           want.quantized, rsp_quantized, want.last, rsp_last_out);
            end
         end
      end
   end

   // register write over the csr channel, shadow updated on the transfer
   task automatic write_csr(logic [CsrAddrWidth-1:0] index, logic [31:0] data);
      csr_index <= index;
      csr_data <= data;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (index == CSR_SCALE) model_scale = data;
      else model_narrow = data[0];
   endtask

   // waits until every queued sample is sent and every predicted result has come back
   task automatic wait_drained();
      while (pending_samples.size() > 0 || start || gap_left > 0 ||
             expected_quants.size() > 0)
         @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++)
         pending_samples.push_back('{random_sample(model_scale), $urandom_range(0, 7) == 0});
   endtask

   initial begin
      logic [31:0] directed[$];
      logic [31:0] scales[$];
      logic        modes[$];
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h7f80_0000, 32'hff80_0000,
                   32'h7fc0_0000, 32'hffff_ffff, 32'h0000_0001, 32'h007f_ffff,
                   32'h3f00_0000, 32'h3fc0_0000, 32'h4020_0000, 32'hbf00_0000,
                   32'hbfc0_0000, 32'h46ff_fe00, 32'h4700_0000, 32'hc700_0000,
                   32'hc700_0100, 32'h4f00_0000, 32'hcf00_0000, 32'h7f7f_ffff,
                   32'h42fe_0000, 32'hc300_0000, 32'h3f7f_ffff, 32'hc2fe_0000};
      // scale and width per phase, extremes and specials included
      scales = '{32'h3f80_0000, 32'h3c23_d70a, 32'h0000_0001, 32'h7f7f_ffff,
                 32'h7fc0_0000, 32'hff80_0000, 32'h8000_0000, 32'hbf80_0000,
                 $urandom(), $urandom(), 32'h3f80_0000};
      modes = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1,
                1'($urandom()), 1'($urandom()), 1'b0};
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings first: directed corners, then random
      foreach (directed[i]) pending_samples.push_back('{directed[i], i[0]});
      queue_random(40);
      wait_drained();

      foreach (scales[k]) begin
         write_csr(CSR_SCALE, scales[k]);
         write_csr(CSR_NARROW, {$urandom() & 32'hffff_fffe} | modes[k]);
         if (k < 2) foreach (directed[i]) pending_samples.push_back('{directed[i], 1'b0});
         queue_random(60);
         wait_drained();
      end

      if (mismatch_count == 0) begin
         $display("testbench: clean");
      end else begin
         $display("testbench: errors");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("testbench: errors");
      $finish;
   end

endmodule
